// ----- hdl/gubp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package gubp_pkg;
  localparam int MAX_GROUP_DEF = 64;
  localparam int VAL_W = 24;
  localparam int OUT_W = 18;
  localparam int SUM_W = 53;
  localparam int ROOT_W = 27;
  localparam int QUO_W = 17;
  localparam int DIV_STEPS = 40;
  localparam logic [ROOT_W-1:0] ONE_Q16 = 27'd65536;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SQRT,
    ST_READ,
    ST_DIV,
    ST_EMIT
  } state_t;
endpackage
`default_nettype wire

// ----- hdl/group_unit_ball_projection_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Group unit-ball projection.
// Input channel: drive in_value (signed Q8.16) and in_group_end with start;
// the element transfers on a clock edge where start is high and busy is low.
// Elements are buffered in an on-chip memory while the sum of squares builds
// up. A group closes on in_group_end or when MAX_GROUP elements are held.
// On close the block takes the floor square root of the sum (one result bit
// per cycle), clamps it to at least 1.0, and then for each buffered element
// reads the memory, runs a restoring divider one quotient bit per cycle and
// presents the result for one cycle on out_scaled with out_valid; out_last
// marks the final element.
// Loading accepts a new element on any cycle where busy is low; the root and
// divider units are bit-serial.
// busy is high from group close until the last result has been presented.
// The receiver cannot stall: each result is held for exactly one cycle.
// Synchronous reset (rst_n low) empties the open group and idles the block;
// memory contents are not cleared and are read only after being written.
module group_unit_ball_projection_top #(
  parameter int MAX_GROUP = gubp_pkg::MAX_GROUP_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  output logic                             busy,
  input  wire  signed [gubp_pkg::VAL_W-1:0] in_value,
  input  wire                              in_group_end,
  output logic                             out_valid,
  output logic signed [gubp_pkg::OUT_W-1:0] out_scaled,
  output logic                             out_last
);
  localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int CW = $clog2(MAX_GROUP + 1);
  localparam int RW = gubp_pkg::ROOT_W;
  localparam int SW = gubp_pkg::SUM_W;
  localparam int DW = gubp_pkg::DIV_STEPS;

  // element store
  logic signed [gubp_pkg::VAL_W-1:0] mem [MAX_GROUP];
  logic signed [gubp_pkg::VAL_W-1:0] rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          wr_en;

  gubp_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [SW-1:0] sum_r, sum_nxt;
  logic [RW-1:0] root_r, root_nxt;
  logic [SW-1:0] rem_r, rem_nxt;
  logic [4:0]    step_r, step_nxt;
  logic [RW-1:0] norm_r, norm_nxt;
  logic [RW:0]   drem_r, drem_nxt;
  logic [DW-1:0] dnum_r, dnum_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [5:0]    dstep_r, dstep_nxt;
  logic          neg_r, neg_nxt;

  logic          take;
  logic [23:0]   mag_in;
  logic [47:0]   sq_in;
  logic [CW-1:0] count_inc;
  logic [SW-1:0] trial;
  logic [RW:0]   dtrial;
  logic [23:0]   mag_rd;
  logic [gubp_pkg::QUO_W:0] q_cut;

  assign take      = start && !busy;
  assign busy      = (state_r != gubp_pkg::ST_LOAD);
  assign count_inc = count_r + 1'b1;
  assign wr_en     = take;
  // read ahead at the index of the next cycle
  assign rd_addr   = idx_nxt[AW-1:0];
  assign mag_in    = in_value[23] ? 24'(-in_value) : 24'(in_value);
  assign sq_in     = mag_in * mag_in;
  assign mag_rd    = rd_data_r[23] ? 24'(-rd_data_r) : 24'(rd_data_r);

  // write on transfer, registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[count_r[AW-1:0]] <= in_value;
    rd_data_r <= mem[rd_addr];
  end

  // root trial: rem >= (root<<(step+1)) + (1<<(2*step))
  always_comb begin
    trial = (SW'(root_r) << (step_r + 5'd1)) + (SW'(1) << {step_r, 1'b0});
    dtrial = {drem_r[RW-1:0], dnum_r[DW-1]};
    q_cut = quo_r[gubp_pkg::QUO_W:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gubp_pkg::ST_LOAD:
        if (take && (in_group_end || count_inc == CW'(MAX_GROUP)))
          state_nxt = gubp_pkg::ST_SQRT;
      gubp_pkg::ST_SQRT: if (step_r == 5'd0) state_nxt = gubp_pkg::ST_READ;
      gubp_pkg::ST_READ: state_nxt = gubp_pkg::ST_DIV;
      gubp_pkg::ST_DIV:  if (dstep_r == 6'd0) state_nxt = gubp_pkg::ST_EMIT;
      gubp_pkg::ST_EMIT:
        state_nxt = (idx_r + 1'b1 == count_r) ? gubp_pkg::ST_LOAD : gubp_pkg::ST_READ;
      default: state_nxt = gubp_pkg::ST_LOAD;
    endcase
  end

  // datapath updates
  always_comb begin
    count_nxt = count_r;
    idx_nxt   = idx_r;
    sum_nxt   = sum_r;
    root_nxt  = root_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    norm_nxt  = norm_r;
    drem_nxt  = drem_r;
    dnum_nxt  = dnum_r;
    quo_nxt   = quo_r;
    dstep_nxt = dstep_r;
    neg_nxt   = neg_r;
    case (state_r)
      gubp_pkg::ST_LOAD: begin
        idx_nxt = '0;
        if (take) begin
          count_nxt = count_inc;
          sum_nxt   = sum_r + SW'(sq_in);
          rem_nxt   = sum_r + SW'(sq_in);
          root_nxt  = '0;
          step_nxt  = 5'(RW - 1);
        end
      end
      gubp_pkg::ST_SQRT: begin
        // one root bit per cycle
        if (rem_r >= trial) begin
          rem_nxt  = rem_r - trial;
          root_nxt = root_r | (RW'(1) << step_r);
        end
        step_nxt = step_r - 5'd1;
        if (step_r == 5'd0) begin
          norm_nxt = ((rem_r >= trial) ? (root_r | RW'(1)) : root_r);
          if (norm_nxt < gubp_pkg::ONE_Q16) norm_nxt = gubp_pkg::ONE_Q16;
          sum_nxt = '0;
        end
      end
      gubp_pkg::ST_READ: begin
        neg_nxt   = rd_data_r[23];
        dnum_nxt  = {mag_rd, 16'd0};
        drem_nxt  = '0;
        quo_nxt   = '0;
        dstep_nxt = 6'(DW - 1);
      end
      gubp_pkg::ST_DIV: begin
        // one quotient bit per cycle
        if (dtrial >= {1'b0, norm_r}) begin
          drem_nxt = dtrial - {1'b0, norm_r};
          quo_nxt  = {quo_r[DW-2:0], 1'b1};
        end else begin
          drem_nxt = dtrial;
          quo_nxt  = {quo_r[DW-2:0], 1'b0};
        end
        dnum_nxt  = {dnum_r[DW-2:0], 1'b0};
        dstep_nxt = dstep_r - 6'd1;
      end
      gubp_pkg::ST_EMIT: begin
        idx_nxt = idx_r + 1'b1;
        if (idx_r + 1'b1 == count_r) count_nxt = '0;
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    out_valid  = (state_r == gubp_pkg::ST_EMIT);
    out_last   = out_valid && (idx_r + 1'b1 == count_r);
    out_scaled = neg_r ? -$signed(q_cut) : $signed(q_cut);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gubp_pkg::ST_LOAD;
      count_r <= '0;
      idx_r   <= '0;
      sum_r   <= '0;
      step_r  <= '0;
      dstep_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      sum_r   <= sum_nxt;
      step_r  <= step_nxt;
      dstep_r <= dstep_nxt;
    end
    root_r <= root_nxt;
    rem_r  <= rem_nxt;
    norm_r <= norm_nxt;
    drem_r <= drem_nxt;
    dnum_r <= dnum_nxt;
    quo_r  <= quo_nxt;
    neg_r  <= neg_nxt;
  end

  // no transfer while a group is being closed
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !take) else $error("transfer while busy");
  // last result returns to load
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |=> !busy) else $error("not idle after last");
  // clamped norm never below one
  a_norm_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> norm_r >= gubp_pkg::ONE_Q16) else $error("norm below one");
  // quotient magnitude bounded by one
  a_quo_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> quo_r <= DW'(65536)) else $error("quotient too large");
endmodule
`default_nettype wire
